>>> rtl/core/ipv4rt_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 reassembly tracker package
// Shared types and constants for the reassembly context tracker.
// ----------------------------------------------------------------------------
package ipv4rt_pkg;

    localparam int unsigned LEN_W = 17;
    localparam logic [LEN_W-1:0] BYTES_MAX = 17'h1FFFF;
    localparam int unsigned TTL_SHIFT = 4;
    localparam int unsigned OFFS_SHIFT = 3;

    typedef enum logic [2:0] {
        ST_DROPPED  = 3'd0,
        ST_HELD     = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_NO_FREE  = 3'd3,
        ST_TICK     = 3'd4
    } status_t;

    localparam logic CFG_ENABLE   = 1'b0;
    localparam logic CFG_LIFETIME = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] datagram_ident;
        logic [7:0]  protocol_number;
        logic [12:0] offset_units;
        logic        more_fragments;
        logic        dont_fragment;
        logic [7:0]  hop_ttl;
        logic [15:0] payload_len;
    } item_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [16:0] datagram_len;
        logic [4:0]  expired_count;
    } item_out_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic update;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } ctrl_sts_t;

endpackage

>>> rtl/core/ipv4rt_ctrl.sv
// ----------------------------------------------------------------------------
// IPv4 reassembly tracker controller
// Sequences capture, table scan, update and result for each item.
// ----------------------------------------------------------------------------
module ipv4rt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output ipv4rt_pkg::ctrl_cmd_t  cmd,
    input  ipv4rt_pkg::ctrl_sts_t  sts
);
    import ipv4rt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (start) state_next = S_SCAN;
            S_SCAN:   if (sts.scan_last) state_next = S_UPDATE;
            S_UPDATE: state_next = S_EMIT;
            S_EMIT:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.scan    = (state_reg == S_SCAN);
    assign cmd.update  = (state_reg == S_UPDATE);
    assign cmd.emit    = (state_reg == S_EMIT);

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("controller state not one-hot");
    a_emit_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> cmd.emit) else $error("update not followed by emit");
    a_scan_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.scan) else $error("capture not followed by scan");
`endif
endmodule

>>> rtl/core/ipv4rt_dp.sv
// ----------------------------------------------------------------------------
// IPv4 reassembly tracker datapath
// Context table, sequential match and free search, update and result.
// ----------------------------------------------------------------------------
module ipv4rt_dp #(
    parameter int unsigned CONTEXTS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_data,
    input  ipv4rt_pkg::item_in_t   in_item,
    input  ipv4rt_pkg::ctrl_cmd_t  cmd,
    output ipv4rt_pkg::ctrl_sts_t  sts,
    output logic                   done,
    output ipv4rt_pkg::item_out_t  out_item
);
    import ipv4rt_pkg::*;

    localparam int unsigned IW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int unsigned CW = $clog2(CONTEXTS + 1);

    logic              enable_reg;
    logic [7:0]        init_life_reg;
    item_in_t          item_reg;

    logic [CONTEXTS-1:0] valid_reg;
    logic [31:0]       src_mem  [CONTEXTS];
    logic [31:0]       dst_mem  [CONTEXTS];
    logic [15:0]       id_mem   [CONTEXTS];
    logic [7:0]        pr_mem   [CONTEXTS];
    logic [LEN_W-1:0]  bytes_mem[CONTEXTS];
    logic [LEN_W-1:0]  end_mem  [CONTEXTS];
    logic [7:0]        life_mem [CONTEXTS];
    logic              last_mem [CONTEXTS];

    logic [IW-1:0]     idx_reg;
    logic              hit_reg, free_reg;
    logic [IW-1:0]     hit_idx_reg, free_idx_reg;
    logic [4:0]        exp_reg;
    item_out_t         out_reg;
    logic              done_reg;

    logic              key_eq;
    logic              is_frag;
    assign is_frag = !item_reg.action && enable_reg && !item_reg.dont_fragment;
    assign key_eq  = valid_reg[idx_reg] && src_mem[idx_reg] == item_reg.source_address
                   && dst_mem[idx_reg] == item_reg.dest_address
                   && id_mem[idx_reg] == item_reg.datagram_ident
                   && pr_mem[idx_reg] == item_reg.protocol_number;
    assign sts.scan_last = (CW'(idx_reg) == CW'(CONTEXTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            init_life_reg <= 8'd15;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:   enable_reg    <= cfg_data[0];
                CFG_LIFETIME: init_life_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    logic [IW-1:0]    us;
    logic             ualloc;
    logic [LEN_W-1:0] ubytes0, uend0, usum, ubytes, uend, fend;
    logic [7:0]       ulife0, nlife;
    logic             ulast, ucomp;
    always_comb
    begin
        ualloc  = !hit_reg;
        us      = hit_reg ? hit_idx_reg : free_idx_reg;
        ubytes0 = ualloc ? '0 : bytes_mem[us];
        uend0   = ualloc ? '0 : end_mem[us];
        ulife0  = ualloc ? init_life_reg : life_mem[us];
        nlife   = 8'(item_reg.hop_ttl >> TTL_SHIFT);
        usum    = ubytes0 + LEN_W'(item_reg.payload_len);
        ubytes  = (usum < ubytes0) ? BYTES_MAX : usum;
        fend    = (LEN_W'(item_reg.offset_units) << OFFS_SHIFT)
                + LEN_W'(item_reg.payload_len);
        uend    = (fend > uend0) ? fend : uend0;
        ulast   = (ualloc ? 1'b0 : last_mem[us]) || !item_reg.more_fragments;
        ucomp   = ulast && (ubytes == uend);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_item;
        if (cmd.update && is_frag && (hit_reg || free_reg))
        begin
            src_mem[us]   <= item_reg.source_address;
            dst_mem[us]   <= item_reg.dest_address;
            id_mem[us]    <= item_reg.datagram_ident;
            pr_mem[us]    <= item_reg.protocol_number;
            bytes_mem[us] <= ubytes;
            end_mem[us]   <= uend;
            life_mem[us]  <= (nlife > ulife0) ? nlife : ulife0;
            last_mem[us]  <= ulast;
        end
        if (cmd.scan && item_reg.action && valid_reg[idx_reg] && life_mem[idx_reg] != 8'd0)
            life_mem[idx_reg] <= life_mem[idx_reg] - 8'd1;
        if (cmd.update)
        begin
            if (item_reg.action)
                out_reg <= '{ST_TICK, 4'd0, '0, exp_reg};
            else if (!is_frag)
                out_reg <= '{ST_DROPPED, 4'd0, '0, 5'd0};
            else if (!(hit_reg || free_reg))
                out_reg <= '{ST_NO_FREE, 4'd0, '0, 5'd0};
            else
                out_reg <= '{ucomp ? ST_COMPLETE : ST_HELD, 4'(us), uend, 5'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
            exp_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
            if (cmd.capture)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
                exp_reg  <= '0;
            end
            if (cmd.scan)
            begin
                idx_reg <= sts.scan_last ? '0 : idx_reg + 1'b1;
                if (item_reg.action)
                begin
                    if (valid_reg[idx_reg] && life_mem[idx_reg] == 8'd0)
                    begin
                        valid_reg[idx_reg] <= 1'b0;
                        if (exp_reg != 5'd31)
                            exp_reg <= exp_reg + 5'd1;
                    end
                end
                else
                begin
                    if (key_eq && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                    end
                    if (!valid_reg[idx_reg] && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                end
            end
            if (cmd.update && is_frag && (hit_reg || free_reg))
                valid_reg[us] <= !ucomp;
        end
    end

    assign done     = done_reg;
    assign out_item = out_reg;

`ifndef SYNTHESIS
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> done) else $error("result missing after update");
    a_tick_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_item.status == ST_TICK |-> out_item.slot == 4'd0)
        else $error("tick result carries a slot");
    a_frag_no_expire: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_item.status != ST_TICK |-> out_item.expired_count == 5'd0)
        else $error("fragment result carries an expiry count");
`endif
endmodule

>>> rtl/core/ipv4_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// IPv4 reassembly tracker
// Tracks IPv4 fragment reassembly contexts and reports completion.
// ----------------------------------------------------------------------------
// Usage: raise start with an item on item_in while busy is low; the item is
// taken at that edge and busy stays high until the result has been shown.
// Each item gives exactly one result on item_out, marked by done for one
// cycle; the receiver cannot stall, so the result must be taken then.
// After acceptance the block scans the table sequentially, one context at
// a time, then performs the update, then shows the result with done.
// The next item may be started in the cycle after done.
// Configuration: cfg_we, cfg_index and cfg_data write register 0 (enable)
// or register 1 (initial lifetime); the user must do so only while the block
// is idle, which the block does not enforce. Reset clears all contexts,
// sets enable to 1 and the initial lifetime to 15, and leaves the block idle.
// ----------------------------------------------------------------------------
module ipv4_reassembly_tracker #(
    parameter int unsigned CONTEXTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ipv4rt_pkg::item_in_t  item_in,
    output logic                  done,
    output ipv4rt_pkg::item_out_t item_out,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data
);
    import ipv4rt_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    ipv4rt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    ipv4rt_dp #(.CONTEXTS(CONTEXTS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (item_in),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .out_item  (item_out)
    );
endmodule
